/* rtl/isam_pkg.sv */
// Package with the shared types, codes and helper functions of the input source arbiter.
package isam_pkg;

  // Switch codes.
  localparam logic [7:0] SW_UP   = 8'd1;
  localparam logic [7:0] SW_DOWN = 8'd2;
  localparam logic [7:0] SW_MID  = 8'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIX_MODE  = 2'd0;
  localparam logic [1:0] CFG_PREFERRED = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;
  localparam logic [1:0] CFG_BOARD_MSK = 2'd3;

  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] MAX_AGE = 32'hFFFF_FFFF;

  // Input word kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [2:0]         source;
    logic [63:0]        sticks_low;
    logic signed [15:0] stick_four;
    logic [47:0]        mouse_axes;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic [15:0]        switch_codes;
    logic               board_key_down;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         chosen_source;
    logic [63:0]        out_sticks_low;
    logic signed [15:0] out_stick_four;
    logic [47:0]        out_mouse_axes;
    logic [15:0]        out_mouse_buttons;
    logic [15:0]        out_key_bits;
    logic [15:0]        out_switch_codes;
    logic               source_changed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic apply;
    logic scan;
    logic fetch;
    logic commit;
  } isam_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_commit;
  } isam_sts_t;

  // Magnitude of a 16-bit two's complement value; -32768 gives 32768.
  function automatic logic [16:0] mag16(input logic [15:0] v);
    logic [16:0] r;
    if (v[15]) begin
      r = 17'h10000 - {1'b0, v};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  // Unknown switch codes become down.
  function automatic logic [7:0] fix_sw(input logic [7:0] c);
    logic [7:0] r;
    if (c == SW_UP || c == SW_MID || c == SW_DOWN) begin
      r = c;
    end else begin
      r = SW_DOWN;
    end
    return r;
  endfunction

endpackage

/* rtl/isam_if.sv */
// Valid/ready stream interfaces for the input and result words.
interface isam_in_if import isam_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface isam_out_if import isam_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/isam_ctrl.sv */
// Controller state machine: sequences accept, apply, source scan, fetch and commit.
module isam_ctrl import isam_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output isam_cmd_t        cmd,
  output logic [IDX_W-1:0] scan_idx,
  input  isam_sts_t        sts
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_APPLY  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_FETCH  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign scan_idx = idx_r;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        idx_nxt   = FIRST_IDX;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FETCH;
        end else begin
          idx_nxt = idx_r + FIRST_IDX;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= FIRST_IDX;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  // The scan index stays within the source range while scanning.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (idx_r >= FIRST_IDX && idx_r <= LAST_IDX))
    else $error("scan index out of range");
  // Applying a word is always followed by the scan.
  a_apply_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY |=> state_r == ST_SCAN)
    else $error("apply not followed by scan");
  // A result waits while the output register is full and not being read.
  a_commit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && !sts.can_commit) |=> state_r == ST_COMMIT)
    else $error("commit left while output blocked");
`endif

endmodule

/* rtl/isam_dp.sv */
// Datapath: configuration, tick counter, source snapshots, scan accumulators, output register.
module isam_dp import isam_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int IDX_W = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  isam_cmd_t             cmd,
  input  logic [IDX_W-1:0]      scan_idx,
  output isam_sts_t             sts,
  isam_out_if.source            out_ch
);

  localparam int DEPTH = NUM_SOURCES + 1;

  // Configuration registers.
  logic        mix_r;
  logic [2:0]  pref_r;
  logic [31:0] timeout_r;
  logic [15:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r     <= 1'b0;
      pref_r    <= '0;
      timeout_r <= '0;
      mask_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIX_MODE:  mix_r     <= cfg_wdata[0];
        CFG_PREFERRED: pref_r    <= cfg_wdata[2:0];
        CFG_TIMEOUT:   timeout_r <= cfg_wdata[31:0];
        CFG_BOARD_MSK: mask_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Held input word.
  in_item_t in_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // Tick counter and snapshot store; entry 0 is never written.
  logic [31:0] now_r;
  logic        valid_r  [DEPTH];
  logic [31:0] stamp_r  [DEPTH];
  logic [63:0] sticks_r [DEPTH];
  logic [15:0] four_r   [DEPTH];
  logic [47:0] mouse_r  [DEPTH];
  logic [15:0] btn_r    [DEPTH];
  logic [15:0] key_r    [DEPTH];
  logic [15:0] sw_r     [DEPTH];

  logic             upd;
  logic [IDX_W-1:0] wr_idx;
  assign upd = cmd.apply && (in_r.kind == KIND_UPDATE) && (in_r.source != 3'd0) &&
               ({29'd0, in_r.source} <= 32'(NUM_SOURCES));
  assign wr_idx = IDX_W'(in_r.source);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.apply && in_r.kind == KIND_TICK) begin
        now_r <= now_r + 32'd1;
      end
      if (upd) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      stamp_r[wr_idx]  <= now_r;
      sticks_r[wr_idx] <= in_r.sticks_low;
      four_r[wr_idx]   <= in_r.stick_four;
      mouse_r[wr_idx]  <= in_r.mouse_axes;
      btn_r[wr_idx]    <= in_r.mouse_buttons;
      key_r[wr_idx]    <= in_r.key_bits;
      sw_r[wr_idx]     <= in_r.switch_codes;
    end
  end

  // Scan accumulators and the chosen source.
  logic [31:0] min_age_r;
  logic [2:0]  latest_r, chosen_r, last_r;
  logic        pref_act_r;
  logic [63:0] acc_sticks_r;
  logic [15:0] acc_four_r;
  logic [47:0] acc_mouse_r;
  logic [15:0] acc_btn_r, acc_key_r;
  logic [2:0]  chosen_nxt;

  assign chosen_nxt = mix_r ? latest_r : (pref_act_r ? pref_r : latest_r);

  // One read port: scan index while scanning, chosen source while fetching.
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      age;
  logic             act;
  assign rd_idx = cmd.fetch ? IDX_W'(chosen_nxt) : scan_idx;
  assign age    = now_r - stamp_r[rd_idx];
  assign act    = valid_r[rd_idx] && (timeout_r == 32'd0 || age <= timeout_r);

  // Lane-wise merge: keep the value of strictly larger magnitude.
  logic [63:0] m_sticks;
  logic [15:0] m_four;
  logic [47:0] m_mouse;
  always_comb begin
    m_sticks = acc_sticks_r;
    m_mouse  = acc_mouse_r;
    m_four   = acc_four_r;
    for (int l = 0; l < 4; l++) begin
      if (mag16(sticks_r[rd_idx][16*l +: 16]) > mag16(acc_sticks_r[16*l +: 16])) begin
        m_sticks[16*l +: 16] = sticks_r[rd_idx][16*l +: 16];
      end
    end
    for (int l = 0; l < 3; l++) begin
      if (mag16(mouse_r[rd_idx][16*l +: 16]) > mag16(acc_mouse_r[16*l +: 16])) begin
        m_mouse[16*l +: 16] = mouse_r[rd_idx][16*l +: 16];
      end
    end
    if (mag16(four_r[rd_idx]) > mag16(acc_four_r)) begin
      m_four = four_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      min_age_r    <= MAX_AGE;
      latest_r     <= '0;
      pref_act_r   <= 1'b0;
      acc_sticks_r <= '0;
      acc_four_r   <= '0;
      acc_mouse_r  <= '0;
      acc_btn_r    <= '0;
      acc_key_r    <= '0;
    end else if (cmd.scan && act) begin
      if (age < min_age_r) begin
        min_age_r <= age;
        latest_r  <= 3'(scan_idx);
      end
      if (pref_r == 3'(scan_idx)) begin
        pref_act_r <= 1'b1;
      end
      acc_sticks_r <= m_sticks;
      acc_four_r   <= m_four;
      acc_mouse_r  <= m_mouse;
      acc_btn_r    <= acc_btn_r | btn_r[rd_idx];
      acc_key_r    <= acc_key_r | key_r[rd_idx];
    end
  end

  // Fetched snapshot of the chosen source.
  logic [63:0] f_sticks;
  logic [15:0] f_four, f_btn, f_key, f_sw;
  logic [47:0] f_mouse;
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      chosen_r <= chosen_nxt;
      f_sticks <= sticks_r[rd_idx];
      f_four   <= four_r[rd_idx];
      f_mouse  <= mouse_r[rd_idx];
      f_btn    <= btn_r[rd_idx];
      f_key    <= key_r[rd_idx];
      f_sw     <= sw_r[rd_idx];
    end
  end

  // Result word assembly.
  out_item_t res;
  logic [15:0] keys;
  always_comb begin
    res = '0;
    res.chosen_source    = chosen_r;
    res.out_switch_codes = {SW_DOWN, SW_DOWN};
    if (chosen_r != 3'd0) begin
      res.out_switch_codes = {fix_sw(f_sw[15:8]), fix_sw(f_sw[7:0])};
      if (mix_r) begin
        res.out_sticks_low    = acc_sticks_r;
        res.out_stick_four    = acc_four_r;
        res.out_mouse_axes    = acc_mouse_r;
        res.out_mouse_buttons = acc_btn_r;
        keys                  = acc_key_r;
      end else begin
        res.out_sticks_low    = f_sticks;
        res.out_stick_four    = f_four;
        res.out_mouse_axes    = f_mouse;
        res.out_mouse_buttons = f_btn;
        keys                  = f_key;
      end
    end else begin
      keys = '0;
    end
    if (in_r.board_key_down) begin
      keys = keys | mask_r;
    end
    res.out_key_bits   = keys;
    res.source_changed = (chosen_r != last_r);
  end

  // Output register.
  logic      out_valid_r;
  out_item_t out_r;
  assign sts.can_commit = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.data    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
      last_r      <= chosen_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

endmodule

/* rtl/input_source_arbiter_merge_top.sv */
// Top level of the input source arbiter: controller, datapath and ports.
// Each accepted word (a source snapshot update or one tick) produces one result word.
// A word passes through the controller states in order: it is captured while idle, the
// update or tick is applied, the sources are scanned one at a time over the snapshot
// store's single read port, the chosen snapshot is fetched and the result is committed.
// The result register is loaded on the commit; the commit waits as long as an earlier
// result is still unread. The next word is taken in the cycle after the commit, while a
// result waits to be read.
module input_source_arbiter_merge_top import isam_pkg::*; #(
  parameter int NUM_SOURCES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  isam_in_if.sink               in_ch,
  isam_out_if.source            out_ch
);

  localparam int IDX_W = $clog2(NUM_SOURCES + 1);

  isam_cmd_t        cmd;
  isam_sts_t        sts;
  logic [IDX_W-1:0] scan_idx;

  isam_ctrl #(
    .NUM_SOURCES(NUM_SOURCES),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .cmd(cmd),
    .scan_idx(scan_idx),
    .sts(sts)
  );

  isam_dp #(
    .NUM_SOURCES(NUM_SOURCES),
    .IDX_W(IDX_W)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_data(in_ch.data),
    .cmd(cmd),
    .scan_idx(scan_idx),
    .sts(sts),
    .out_ch(out_ch)
  );

endmodule

/* dv/tb_input_source_arbiter_merge_top.sv */
// Self-checking testbench for the input source arbiter with a built-in predictor.
`timescale 1ns / 100ps

module tb_input_source_arbiter_merge_top;
  import isam_pkg::*;

  localparam int NSRC = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_MIX_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  isam_in_if in_ch ();
  isam_out_if out_ch ();

  input_source_arbiter_merge_top #(.NUM_SOURCES(NSRC)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and configuration.
  logic        pr_mix;
  logic [2:0]  pr_pref;
  logic [31:0] pr_timeout;
  logic [15:0] pr_mask;
  logic [31:0] pr_now;
  logic        pr_valid [1:NSRC];
  logic [31:0] pr_stamp [1:NSRC];
  logic [63:0] pr_sticks [1:NSRC];
  logic [15:0] pr_four [1:NSRC];
  logic [47:0] pr_mouse [1:NSRC];
  logic [15:0] pr_btn [1:NSRC];
  logic [15:0] pr_keys [1:NSRC];
  logic [15:0] pr_sw [1:NSRC];
  logic [2:0]  pr_last;

  out_item_t expected_words[$];
  int fail_count = 0;
  int idle_cycles = 0;
  logic rx_hold = 1'b0;
  logic rx_random = 1'b1;

  function automatic logic src_active(int s);
    if (s < 1 || s > NSRC) return 1'b0;
    if (!pr_valid[s]) return 1'b0;
    if (pr_timeout == 32'd0) return 1'b1;
    return (pr_now - pr_stamp[s]) <= pr_timeout;
  endfunction

  function automatic logic [16:0] lane_mag(logic [15:0] v);
    return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  function automatic logic [7:0] clean_sw(logic [7:0] c);
    return (c == SW_UP || c == SW_MID || c == SW_DOWN) ? c : SW_DOWN;
  endfunction

  function automatic logic [63:0] merge_lane_set(logic [63:0] acc, logic [63:0] v, int n);
    for (int i = 0; i < n; i++) begin
      if (lane_mag(v[16*i +: 16]) > lane_mag(acc[16*i +: 16])) acc[16*i +: 16] = v[16*i +: 16];
    end
    return acc;
  endfunction

  // Applies one word to the predictor and returns the expected result word.
  function automatic out_item_t arbitrate(in_item_t w);
    out_item_t r;
    int latest, chosen;
    logic [31:0] min_age, age;
    logic [63:0] sticks, four, mouse;
    logic [15:0] btn, keys, sw;
    sticks = '0; four = '0; mouse = '0; btn = '0; keys = '0;
    sw = {SW_DOWN, SW_DOWN};
    if (w.kind == KIND_TICK) begin
      pr_now = pr_now + 32'd1;
    end else if (w.source >= 1 && w.source <= NSRC) begin
      pr_sticks[w.source] = w.sticks_low;
      pr_four[w.source] = w.stick_four;
      pr_mouse[w.source] = w.mouse_axes;
      pr_btn[w.source] = w.mouse_buttons;
      pr_keys[w.source] = w.key_bits;
      pr_sw[w.source] = w.switch_codes;
      pr_stamp[w.source] = pr_now;
      pr_valid[w.source] = 1'b1;
    end
    latest = 0;
    min_age = MAX_AGE;
    for (int s = 1; s <= NSRC; s++) begin
      age = pr_now - pr_stamp[s];
      if (src_active(s) && age < min_age) begin
        min_age = age;
        latest = s;
      end
    end
    if (pr_mix) begin
      chosen = latest;
      if (chosen != 0) begin
        sw = {clean_sw(pr_sw[chosen][15:8]), clean_sw(pr_sw[chosen][7:0])};
        for (int s = 1; s <= NSRC; s++) begin
          if (src_active(s)) begin
            sticks = merge_lane_set(sticks, pr_sticks[s], 4);
            four = merge_lane_set(four, {48'd0, pr_four[s]}, 1);
            mouse = merge_lane_set(mouse, {16'd0, pr_mouse[s]}, 3);
            btn |= pr_btn[s];
            keys |= pr_keys[s];
          end
        end
      end
    end else begin
      chosen = pr_pref;
      if (chosen == 0 || !src_active(chosen)) chosen = latest;
      if (chosen != 0) begin
        sticks = pr_sticks[chosen];
        four = {48'd0, pr_four[chosen]};
        mouse = {16'd0, pr_mouse[chosen]};
        btn = pr_btn[chosen];
        keys = pr_keys[chosen];
        sw = {clean_sw(pr_sw[chosen][15:8]), clean_sw(pr_sw[chosen][7:0])};
      end
    end
    if (pr_mask != 16'd0 && w.board_key_down) keys |= pr_mask;
    r.chosen_source = chosen[2:0];
    r.out_sticks_low = sticks;
    r.out_stick_four = four[15:0];
    r.out_mouse_axes = mouse[47:0];
    r.out_mouse_buttons = btn;
    r.out_key_bits = keys;
    r.out_switch_codes = sw;
    r.source_changed = (chosen[2:0] != pr_last);
    pr_last = chosen[2:0];
    return r;
  endfunction

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one word and records its expected result once accepted.
  task automatic send_word(in_item_t w, logic with_gaps = 1'b1);
    int g;
    g = with_gaps ? gap_len() : 0;
    // The word goes out on a falling edge, after the previous one was withdrawn and any random gap has passed.
    repeat (g + 1) @(negedge clk);
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    // Ready comes from a register, so its value here holds up to the next rising edge.
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    expected_words.push_back(arbitrate(w));
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected word has arrived, plus the block latency.
  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (NSRC + 6) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIX_MODE:  pr_mix = val[0];
      CFG_PREFERRED: pr_pref = val[2:0];
      CFG_TIMEOUT:   pr_timeout = val;
      default:       pr_mask = val[15:0];
    endcase
  endtask

  task automatic set_config(logic mix, logic [2:0] pref, logic [31:0] tmo, logic [15:0] msk);
    drain();
    write_reg(CFG_MIX_MODE, {31'd0, mix});
    write_reg(CFG_PREFERRED, {29'd0, pref});
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_BOARD_MSK, {16'd0, msk});
  endtask

  function automatic logic [15:0] rand_lane();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] rand_sw();
    case ($urandom_range(0, 4))
      0: return SW_UP;
      1: return SW_MID;
      2: return SW_DOWN;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_update(logic [2:0] src);
    in_item_t w;
    w.kind = KIND_UPDATE;
    w.source = src;
    w.sticks_low = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
    w.stick_four = rand_lane();
    w.mouse_axes = {rand_lane(), rand_lane(), rand_lane()};
    w.mouse_buttons = 16'($urandom());
    w.key_bits = 16'($urandom());
    w.switch_codes = {rand_sw(), rand_sw()};
    w.board_key_down = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_item_t rand_word();
    in_item_t w;
    w = rand_update(($urandom_range(0, 99) < 92) ? 3'($urandom_range(1, NSRC))
                                                 : 3'($urandom_range(0, 7)));
    if ($urandom_range(0, 99) < 45) w.kind = KIND_TICK;
    return w;
  endfunction

  // Directed: extreme values, bad sources, switch cleanup and board key.
  task automatic test_directed();
    in_item_t w;
    set_config(1'b0, 3'd0, 32'd0, 16'hFFFF);
    w = rand_update(3'd0);
    send_word(w);
    w = rand_update(3'd1);
    w.sticks_low = '1; w.stick_four = 16'sh7FFF; w.mouse_axes = '0;
    w.switch_codes = 16'h0301; w.board_key_down = 1'b1;
    send_word(w);
    w = rand_update(3'd2);
    w.sticks_low = 64'h8000_8000_8000_8000; w.stick_four = -16'sd32768;
    w.mouse_axes = '1; w.mouse_buttons = '1; w.key_bits = '1; w.switch_codes = 16'hFF00;
    send_word(w);
    w = rand_update(3'd5); send_word(w);
    w = rand_update(3'd7); send_word(w);
    w.kind = KIND_TICK; send_word(w);
    set_config(1'b0, 3'd7, 32'd1, 16'h0000);
    for (int i = 0; i < 3; i++) begin
      w.kind = KIND_TICK; w.board_key_down = i[0]; send_word(w);
    end
    set_config(1'b1, 3'd4, 32'hFFFF_FFFF, 16'h8001);
    for (int s = 1; s <= NSRC; s++) send_word(rand_update(s[2:0]));
    w.kind = KIND_TICK; send_word(w);
    set_config(1'b1, 3'd1, 32'd0, 16'h0001);
    send_word(rand_update(3'd3));
  endtask

  // Random words, with a fresh random configuration every 150 words.
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        set_config(1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)),
                   ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 40)),
                   ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()));
      end
      send_word(rand_word());
    end
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    drain();
    rx_random = 1'b0;
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        rx_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_word(rand_word(), 1'b0);
      end
    join
    rx_random = 1'b1;
    drain();
  endtask

  // Receiver ready pattern.
  initial begin
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_random) begin
        out_ch.ready <= 1'b1;
        g = gap_len();
        if (g != 0) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_item_t exp_w, got;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          $error("result word with no expectation");
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.chosen_source !== exp_w.chosen_source) begin
            $error("chosen_source exp %0d got %0d", exp_w.chosen_source, got.chosen_source);
            fail_count++;
          end
          if (got.out_sticks_low !== exp_w.out_sticks_low) begin
            $error("out_sticks_low exp %h got %h", exp_w.out_sticks_low, got.out_sticks_low);
            fail_count++;
          end
          if (got.out_stick_four !== exp_w.out_stick_four) begin
            $error("out_stick_four exp %h got %h", exp_w.out_stick_four, got.out_stick_four);
            fail_count++;
          end
          if (got.out_mouse_axes !== exp_w.out_mouse_axes) begin
            $error("out_mouse_axes exp %h got %h", exp_w.out_mouse_axes, got.out_mouse_axes);
            fail_count++;
          end
          if (got.out_mouse_buttons !== exp_w.out_mouse_buttons) begin
            $error("out_mouse_buttons exp %h got %h", exp_w.out_mouse_buttons,
                   got.out_mouse_buttons);
            fail_count++;
          end
          if (got.out_key_bits !== exp_w.out_key_bits) begin
            $error("out_key_bits exp %h got %h", exp_w.out_key_bits, got.out_key_bits);
            fail_count++;
          end
          if (got.out_switch_codes !== exp_w.out_switch_codes) begin
            $error("out_switch_codes exp %h got %h", exp_w.out_switch_codes,
                   got.out_switch_codes);
            fail_count++;
          end
          if (got.source_changed !== exp_w.source_changed) begin
            $error("source_changed exp %0d got %0d", exp_w.source_changed, got.source_changed);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    pr_mix = 1'b0; pr_pref = '0; pr_timeout = '0; pr_mask = '0; pr_now = '0; pr_last = '0;
    for (int s = 1; s <= NSRC; s++) begin
      pr_valid[s] = 1'b0; pr_stamp[s] = '0; pr_sticks[s] = '0; pr_four[s] = '0;
      pr_mouse[s] = '0; pr_btn[s] = '0; pr_keys[s] = '0; pr_sw[s] = {SW_DOWN, SW_DOWN};
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(520);
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
